### sv/led_strip_frame_serializer_assert.svh
// Assertion macros for the LED strip frame serializer.
`ifndef LED_STRIP_FRAME_SERIALIZER_ASSERT_SVH
`define LED_STRIP_FRAME_SERIALIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsfs assertion failed");

// Next-cycle implication, checked outside reset.
`define LSFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsfs assertion failed");

`endif

### sv/lsfs_pkg.sv
`timescale 1ns / 1ps
package lsfs_pkg;

  // command codes on the input channel
  localparam logic [1:0] CMD_SET_ALL    = 2'd0;
  localparam logic [1:0] CMD_SET_COLOR  = 2'd1;
  localparam logic [1:0] CMD_SET_BRIGHT = 2'd2;
  localparam logic [1:0] CMD_REFRESH    = 2'd3;

  localparam logic [7:0] HDR_BASE = 8'd224;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] led_index;
    logic [7:0] hdr;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] hdr;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_entry_t;

endpackage

### sv/lsfs_front.sv
`timescale 1ns / 1ps
module lsfs_front #(
  parameter int LED_COUNT = 12
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [3:0]        led_index,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [4:0]        brightness,
  input  logic              q_full,
  output logic              q_push,
  output lsfs_pkg::q_entry_t q_din
);

  logic in_range;
  logic keep;

  // set commands aimed past the strip are swallowed here
  assign in_range = led_index < 4'(LED_COUNT);
  assign keep     = (cmd == lsfs_pkg::CMD_REFRESH) || in_range;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

  always_comb begin
    q_din.cmd       = cmd;
    q_din.led_index = led_index;
    q_din.hdr       = lsfs_pkg::HDR_BASE + {3'b000, brightness};
    q_din.blue      = blue;
    q_din.green     = green;
    q_din.red       = red;
  end

endmodule

### sv/lsfs_queue.sv
`timescale 1ns / 1ps
module lsfs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lsfs_pkg::q_entry_t din,
  input  logic               pop,
  output lsfs_pkg::q_entry_t dout,
  output logic               full,
  output logic               empty
);

  lsfs_pkg::q_entry_t mem [lsfs_pkg::QUEUE_DEPTH];
  logic [lsfs_pkg::QPTR_W-1:0] wr_ptr;
  logic [lsfs_pkg::QPTR_W-1:0] rd_ptr;
  logic [lsfs_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = count == lsfs_pkg::QCNT_W'(lsfs_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/lsfs_back.sv
`timescale 1ns / 1ps
module lsfs_back #(
  parameter int LED_COUNT = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  lsfs_pkg::q_entry_t q_dout,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         serial_byte,
  output logic               frame_end
);

  localparam int FRAME_BYTES = 8 + 4 * LED_COUNT;
  localparam int CNT_W       = $clog2(FRAME_BYTES);
  localparam int IDX_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  lsfs_pkg::led_entry_t store [LED_COUNT];

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     pos;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic                 in_data;
  logic                 last;
  logic                 out_load;
  logic [7:0]           byte_next;
  lsfs_pkg::led_entry_t rd_entry;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign out_load = (state == ST_STREAM) && (!out_valid || !out_stall);
  assign last     = cnt == CNT_W'(FRAME_BYTES - 1);
  assign wr_idx   = q_dout.led_index[IDX_W-1:0];

  // position within the LED data region: entry in upper bits, byte in [1:0]
  assign pos      = cnt - CNT_W'(4);
  assign in_data  = (cnt >= CNT_W'(4)) && (cnt < CNT_W'(4 + 4 * LED_COUNT));
  assign rd_idx   = pos[IDX_W+1:2];

  always_comb begin
    rd_entry  = store[rd_idx];
    byte_next = 8'd0;
    if (in_data) begin
      case (pos[1:0])
        2'd0:    byte_next = rd_entry.hdr;
        2'd1:    byte_next = rd_entry.blue;
        2'd2:    byte_next = rd_entry.green;
        default: byte_next = rd_entry.red;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_pop && q_dout.cmd == lsfs_pkg::CMD_REFRESH) begin
          state_next = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (out_load && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        cnt <= '0;
      end else if (out_load) begin
        cnt <= cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      serial_byte <= byte_next;
      frame_end   <= last;
    end
  end

  // frame store; later set commands wait in the queue until a refresh is done
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        store[i] <= '{hdr: lsfs_pkg::HDR_BASE, blue: 8'd0, green: 8'd0, red: 8'd0};
      end
    end else if (q_pop) begin
      case (q_dout.cmd)
        lsfs_pkg::CMD_SET_ALL: begin
          store[wr_idx] <= '{hdr: q_dout.hdr, blue: q_dout.blue,
                             green: q_dout.green, red: q_dout.red};
        end
        lsfs_pkg::CMD_SET_COLOR: begin
          store[wr_idx].blue  <= q_dout.blue;
          store[wr_idx].green <= q_dout.green;
          store[wr_idx].red   <= q_dout.red;
        end
        lsfs_pkg::CMD_SET_BRIGHT: begin
          store[wr_idx].hdr <= q_dout.hdr;
        end
        default: ;
      endcase
    end
  end

endmodule

### sv/led_strip_frame_serializer.sv
`timescale 1ns / 1ps
// LED strip frame serializer.
// Input channel (in_valid / in_stall) takes commands: set all, set color,
// set brightness (each for one led_index) and refresh. Set commands with an
// index past the strip are dropped. Set commands give no output.
// Output channel (out_valid / out_stall) carries one frame byte per item:
// four zero start bytes, header/blue/green/red per LED in index order, then
// four zero end bytes; frame_end marks the last one.
// A two-entry command queue separates intake from the execution side.
// An accepted command is written into the queue, from which the executor
// takes it; a refresh sets the state register to streaming, and its frame
// bytes are loaded into the single output register at one byte per cycle
// while the receiver does not stall. A set command is executed as it is
// popped; a refresh holds the executor until its last byte is loaded. While
// it streams, up to two further commands are queued, and in_stall is raised.
// When the receiver stalls, the output byte holds and streaming pauses.
// Reset empties the queue, drops any pending byte and sets every LED to
// header 224 with colors zero.
module led_strip_frame_serializer #(
  parameter int LED_COUNT = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [3:0] led_index,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [4:0] brightness,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] serial_byte,
  output logic       frame_end
);

  lsfs_pkg::q_entry_t q_din;
  lsfs_pkg::q_entry_t q_dout;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  lsfs_front #(.LED_COUNT(LED_COUNT)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .led_index  (led_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .brightness (brightness),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_din      (q_din)
  );

  lsfs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  lsfs_back #(.LED_COUNT(LED_COUNT)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_dout      (q_dout),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .serial_byte (serial_byte),
    .frame_end   (frame_end)
  );

endmodule

### sv/lsfs_checker.sv
`timescale 1ns / 1ps
`include "led_strip_frame_serializer_assert.svh"
module lsfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] cmd,
  input logic [3:0] led_index,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [4:0] brightness,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] serial_byte,
  input logic       frame_end
);

  // a held item keeps its byte and flag
  `LSFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(serial_byte) && $stable(frame_end))

  // the final byte is an end byte, always zero
  `LSFS_ASSERT_IMP(a_end_zero, out_valid && frame_end, serial_byte == 8'd0)

  // an item right after a frame's last byte, if any, is a zero start byte
  `LSFS_ASSERT_NEXT(a_next_start, out_valid && !out_stall && frame_end, !out_valid || (serial_byte == 8'd0 && !frame_end))

  // nothing is offered right after reset
  `LSFS_ASSERT_IMP(a_rst_quiet, $past(rst), !out_valid)

endmodule

bind led_strip_frame_serializer lsfs_checker u_lsfs_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int LEDS       = 12;
  localparam int RAND_ITEMS = 450;
  localparam int HANG_LIMIT = 4000;
  localparam int TAIL_WAIT  = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [4:0] br;
    logic       fixed;  // refresh expected to show the power-up frame
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] cmd;
  logic [3:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [4:0] brightness;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] serial_byte;
  logic       frame_end;

  lsfs_pkg::led_entry_t frame_store [LEDS];
  frame_byte_t          frame_bytes_due [$];
  frame_byte_t          head_byte;
  stim_row_t            dir_rows [$];

  int errors;
  int bytes_checked;
  int cmds_taken;
  int refreshes;
  int dropped_sets;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  led_strip_frame_serializer #(.LED_COUNT(LEDS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .led_index  (led_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .serial_byte(serial_byte),
    .frame_end  (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic stim_row_t mk_row(input logic [1:0] op, input logic [3:0] idx,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic [4:0] br,
                                       input logic fixed);
    mk_row = '{op, idx, r, g, b, br, fixed};
  endfunction

  // Queue the whole refresh frame: start zeros, per-LED hdr/blue/green/red, end zeros.
  function automatic void queue_refresh(input logic fixed);
    lsfs_pkg::led_entry_t e;
    for (int i = 0; i < 4; i++) frame_bytes_due.push_back('{8'h00, 1'b0});
    for (int i = 0; i < LEDS; i++) begin
      if (fixed) begin
        e = '{lsfs_pkg::HDR_BASE, 8'h00, 8'h00, 8'h00};
      end else begin
        e = frame_store[i];
      end
      frame_bytes_due.push_back('{e.hdr, 1'b0});
      frame_bytes_due.push_back('{e.blue, 1'b0});
      frame_bytes_due.push_back('{e.green, 1'b0});
      frame_bytes_due.push_back('{e.red, 1'b0});
    end
    for (int i = 0; i < 4; i++) frame_bytes_due.push_back('{8'h00, i == 3});
  endfunction

  function automatic void apply_cmd(input stim_row_t s);
    if (s.op == lsfs_pkg::CMD_REFRESH) begin
      queue_refresh(s.fixed);
      refreshes++;
    end else if (s.idx >= LEDS) begin
      dropped_sets++;
    end else begin
      case (s.op)
        lsfs_pkg::CMD_SET_ALL: begin
          frame_store[s.idx] = '{8'(lsfs_pkg::HDR_BASE + s.br), s.b, s.g, s.r};
        end
        lsfs_pkg::CMD_SET_COLOR: begin
          frame_store[s.idx].blue  = s.b;
          frame_store[s.idx].green = s.g;
          frame_store[s.idx].red   = s.r;
        end
        default: begin
          frame_store[s.idx].hdr = 8'(lsfs_pkg::HDR_BASE + s.br);
        end
      endcase
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_cmd(input stim_row_t s);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= s.op;
    led_index  <= s.idx;
    red        <= s.r;
    green      <= s.g;
    blue       <= s.b;
    brightness <= s.br;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_cmd(s);
    cmds_taken++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      bytes_checked++;
      if (frame_bytes_due.size() == 0) begin
        errors++;
        $error("unexpected item: serial_byte %02h frame_end %0b", serial_byte, frame_end);
      end else begin
        head_byte = frame_bytes_due.pop_front();
        if (serial_byte !== head_byte.data) begin
          errors++;
          $error("serial_byte: expected %02h, got %02h", head_byte.data, serial_byte);
        end
        if (frame_end !== head_byte.last) begin
          errors++;
          $error("frame_end: expected %0b, got %0b", head_byte.last, frame_end);
        end
      end
    end
  end

  // Hang detector: no item moving on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", HANG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t s;
    int pick;

    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = lsfs_pkg::CMD_SET_ALL;
    led_index      = 4'd0;
    red            = 8'h00;
    green          = 8'h00;
    blue           = 8'h00;
    brightness     = 5'd0;
    out_stall      = 1'b0;
    errors         = 0;
    bytes_checked  = 0;
    cmds_taken     = 0;
    refreshes      = 0;
    dropped_sets   = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < LEDS; i++) begin
      frame_store[i] = '{lsfs_pkg::HDR_BASE, 8'h00, 8'h00, 8'h00};
    end

    //     op                        idx    red    green  blue   bright fixed
    dir_rows = '{
      mk_row(lsfs_pkg::CMD_REFRESH,    4'd0,  8'h00, 8'h00, 8'h00, 5'd0,  1'b1),
      mk_row(lsfs_pkg::CMD_SET_ALL,    4'd12, 8'hff, 8'hff, 8'hff, 5'd31, 1'b0),
      mk_row(lsfs_pkg::CMD_SET_COLOR,  4'd15, 8'hff, 8'hff, 8'hff, 5'd31, 1'b0),
      mk_row(lsfs_pkg::CMD_SET_BRIGHT, 4'd13, 8'hff, 8'hff, 8'hff, 5'd31, 1'b0),
      // out-of-range sets dropped; refresh ignores its other fields
      mk_row(lsfs_pkg::CMD_REFRESH,    4'd15, 8'hff, 8'hff, 8'hff, 5'd31, 1'b1),
      mk_row(lsfs_pkg::CMD_SET_ALL,    4'd0,  8'hff, 8'hff, 8'hff, 5'd31, 1'b0),
      mk_row(lsfs_pkg::CMD_SET_ALL,    4'd11, 8'h00, 8'h00, 8'h00, 5'd0,  1'b0),
      mk_row(lsfs_pkg::CMD_SET_ALL,    4'd5,  8'h12, 8'h34, 8'h56, 5'd7,  1'b0),
      mk_row(lsfs_pkg::CMD_SET_COLOR,  4'd5,  8'ha5, 8'h5a, 8'hc3, 5'd31, 1'b0),
      mk_row(lsfs_pkg::CMD_SET_BRIGHT, 4'd5,  8'hff, 8'hff, 8'hff, 5'd0,  1'b0),
      mk_row(lsfs_pkg::CMD_SET_COLOR,  4'd10, 8'hff, 8'h00, 8'h80, 5'd0,  1'b0),
      mk_row(lsfs_pkg::CMD_SET_BRIGHT, 4'd6,  8'h00, 8'h00, 8'h00, 5'd31, 1'b0),
      mk_row(lsfs_pkg::CMD_SET_ALL,    4'd3,  8'h01, 8'h02, 8'h04, 5'd16, 1'b0),
      mk_row(lsfs_pkg::CMD_REFRESH,    4'd7,  8'haa, 8'h55, 8'h0f, 5'd21, 1'b0),
      mk_row(lsfs_pkg::CMD_SET_BRIGHT, 4'd0,  8'h00, 8'h00, 8'h00, 5'd0,  1'b0),
      mk_row(lsfs_pkg::CMD_REFRESH,    4'd0,  8'h00, 8'h00, 8'h00, 5'd0,  1'b0)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_cmd(dir_rows[i]);

    // phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 88 : (ph == 3) ? 16 : 0;
      recv_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 16 : 0;
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        pick = $urandom_range(7);
        s.op = (pick == 0) ? lsfs_pkg::CMD_REFRESH :
               (pick < 3)  ? lsfs_pkg::CMD_SET_ALL :
               (pick < 5)  ? lsfs_pkg::CMD_SET_COLOR : lsfs_pkg::CMD_SET_BRIGHT;
        s.idx   = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 12))
                                           : 4'($urandom_range(11));
        s.r     = 8'($urandom);
        s.g     = 8'($urandom);
        s.b     = 8'($urandom);
        s.br    = 5'($urandom);
        s.fixed = 1'b0;
        send_cmd(s);
      end
    end

    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d commands taken: %0d refreshes, %0d out-of-range sets dropped",
             cmds_taken, refreshes, dropped_sets);
    $display("%0d frame bytes checked across idle and stall phases", bytes_checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
